@@ rtl/pmid_pkg.sv @@
`default_nettype none
package pmid_pkg;

  localparam int unsigned COORD_W   = 24;
  localparam int unsigned CELL_W    = 23;
  localparam int unsigned TOL_W     = 12;
  localparam int unsigned DIST_W    = 26;
  localparam int unsigned N_AXES    = 3;
  localparam int unsigned ABS_W     = COORD_W;
  localparam int unsigned WRAP_W    = COORD_W + 1;
  localparam int unsigned SQ_W      = 2 * ABS_W;
  localparam int unsigned SUM_W     = SQ_W + 2;
  localparam int unsigned ROOT_W    = SUM_W / 2;
  localparam int unsigned REM_W     = ROOT_W + 3;
  localparam int unsigned SQ_STEPS  = ROOT_W;
  localparam int unsigned SQ_PER_STG = 2;
  localparam int unsigned SQ_STAGES = (SQ_STEPS + SQ_PER_STG - 1) / SQ_PER_STG;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = CELL_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CELL_LEN_X   = 3'd0,
    CFG_CELL_LEN_Y   = 3'd1,
    CFG_CELL_LEN_Z   = 3'd2,
    CFG_WRAP_TOL     = 3'd3
  } cfg_idx_e;

  localparam logic [CELL_W-1:0] CELL_LEN_RST = CELL_W'(32768);
  localparam logic [TOL_W-1:0]  WRAP_TOL_RST = TOL_W'(4);

  typedef struct packed {
    logic [SUM_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sq_t;

  // one root bit (from two radicand bits) of the restoring square root
  function automatic sq_t sq_step(sq_t s);
    sq_t              r;
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    rem_sh = {s.rem[REM_W-3:0], s.rad[SUM_W-1 -: 2]};
    trial  = {1'b0, s.root, 2'b01};
    r.rad  = {s.rad[SUM_W-3:0], 2'b00};
    if (rem_sh >= trial) begin
      r.rem  = rem_sh - trial;
      r.root = {s.root[ROOT_W-2:0], 1'b1};
    end else begin
      r.rem  = rem_sh;
      r.root = {s.root[ROOT_W-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ rtl/periodic_min_image_distance_core.sv @@
`default_nettype none
// channel  direction  handshake                  payload
// in       sink       in_valid_i / in_stall_o    p_x_i p_y_i p_z_i q_x_i q_y_i q_z_i
// out      source     out_valid_o / out_stall_i  distance_o
// cfg      sink       cfg_valid_i / cfg_ready_o  cfg_index_i cfg_data_i
//
// One request per cycle while the output is not stalled; 5 front stages
// (difference, wrap, magnitude, square, sum) and 13 root stages of two digits each,
// one digit in the last.
// Each stage advances when empty or when the one after it advances; a stall at
// the output fills bubbles before it reaches the input.
// Reset clears all valid bits and loads the register defaults; cfg is always ready.
module periodic_min_image_distance_core (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic signed [pmid_pkg::COORD_W-1:0] p_x_i,
  input  wire logic signed [pmid_pkg::COORD_W-1:0] p_y_i,
  input  wire logic signed [pmid_pkg::COORD_W-1:0] p_z_i,
  input  wire logic signed [pmid_pkg::COORD_W-1:0] q_x_i,
  input  wire logic signed [pmid_pkg::COORD_W-1:0] q_y_i,
  input  wire logic signed [pmid_pkg::COORD_W-1:0] q_z_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic        [pmid_pkg::DIST_W-1:0]      distance_o,
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic   [pmid_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic   [pmid_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int unsigned NA = pmid_pkg::N_AXES;

  logic [pmid_pkg::CELL_W-1:0] cell_len_q [NA];
  logic [pmid_pkg::TOL_W-1:0]  wrap_tol_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_len_q[0] <= pmid_pkg::CELL_LEN_RST;
      cell_len_q[1] <= pmid_pkg::CELL_LEN_RST;
      cell_len_q[2] <= pmid_pkg::CELL_LEN_RST;
      wrap_tol_q    <= pmid_pkg::WRAP_TOL_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (pmid_pkg::cfg_idx_e'(cfg_index_i))
        pmid_pkg::CFG_CELL_LEN_X: cell_len_q[0] <= cfg_data_i;
        pmid_pkg::CFG_CELL_LEN_Y: cell_len_q[1] <= cfg_data_i;
        pmid_pkg::CFG_CELL_LEN_Z: cell_len_q[2] <= cfg_data_i;
        pmid_pkg::CFG_WRAP_TOL:   wrap_tol_q    <= cfg_data_i[pmid_pkg::TOL_W-1:0];
        default: ;
      endcase
    end
  end

  logic signed [pmid_pkg::COORD_W-1:0] p_a [NA];
  logic signed [pmid_pkg::COORD_W-1:0] q_a [NA];

  assign p_a[0] = p_x_i;
  assign p_a[1] = p_y_i;
  assign p_a[2] = p_z_i;
  assign q_a[0] = q_x_i;
  assign q_a[1] = q_y_i;
  assign q_a[2] = q_z_i;

  // stage valids and advance enables
  logic s1_v_q, s2_v_q, s3_v_q, s4_v_q, s5_v_q;
  logic en1, en2, en3, en4, en5;
  logic sq_ready;

  assign en5 = !s5_v_q || sq_ready;
  assign en4 = !s4_v_q || en5;
  assign en3 = !s3_v_q || en4;
  assign en2 = !s2_v_q || en3;
  assign en1 = !s1_v_q || en2;
  assign in_stall_o = !en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
      s5_v_q <= 1'b0;
    end else begin
      if (en1) s1_v_q <= in_valid_i;
      if (en2) s2_v_q <= s1_v_q;
      if (en3) s3_v_q <= s2_v_q;
      if (en4) s4_v_q <= s3_v_q;
      if (en5) s5_v_q <= s4_v_q;
    end
  end

  logic        [pmid_pkg::ABS_W-1:0]  s1_d [NA];
  logic        [pmid_pkg::ABS_W-1:0]  s1_q [NA];
  logic signed [pmid_pkg::WRAP_W-1:0] s2_d [NA];
  logic signed [pmid_pkg::WRAP_W-1:0] s2_q [NA];
  logic        [pmid_pkg::ABS_W-1:0]  s3_d [NA];
  logic        [pmid_pkg::ABS_W-1:0]  s3_q [NA];
  logic        [pmid_pkg::SQ_W-1:0]   s4_d [NA];
  logic        [pmid_pkg::SQ_W-1:0]   s4_q [NA];
  logic        [pmid_pkg::SUM_W-1:0]  s5_d;
  logic        [pmid_pkg::SUM_W-1:0]  s5_q;

  for (genvar a = 0; a < NA; a++) begin : g_axis
    logic signed [pmid_pkg::WRAP_W-1:0] diff;
    logic        [pmid_pkg::WRAP_W-1:0] twice_d;
    logic        [pmid_pkg::WRAP_W-1:0] limit;
    logic        [pmid_pkg::WRAP_W-1:0] neg;

    // absolute difference
    assign diff    = pmid_pkg::WRAP_W'(p_a[a]) - pmid_pkg::WRAP_W'(q_a[a]);
    assign s1_d[a] = diff[pmid_pkg::WRAP_W-1] ? pmid_pkg::ABS_W'(-diff)
                                              : pmid_pkg::ABS_W'(diff);

    // wrap when 2d > L + 2 tol
    assign twice_d = {s1_q[a], 1'b0};
    assign limit   = pmid_pkg::WRAP_W'(cell_len_q[a]) +
                     pmid_pkg::WRAP_W'({wrap_tol_q, 1'b0});
    assign s2_d[a] = (twice_d > limit)
                     ? $signed({1'b0, s1_q[a]}) - $signed(pmid_pkg::WRAP_W'(cell_len_q[a]))
                     : $signed({1'b0, s1_q[a]});

    assign neg     = -s2_q[a];
    assign s3_d[a] = s2_q[a][pmid_pkg::WRAP_W-1] ? neg[pmid_pkg::ABS_W-1:0]
                                                 : s2_q[a][pmid_pkg::ABS_W-1:0];

    assign s4_d[a] = s3_q[a] * s3_q[a];

    always_ff @(posedge clk_i) begin
      if (en1) s1_q[a] <= s1_d[a];
      if (en2) s2_q[a] <= s2_d[a];
      if (en3) s3_q[a] <= s3_d[a];
      if (en4) s4_q[a] <= s4_d[a];
    end
  end

  assign s5_d = pmid_pkg::SUM_W'(s4_q[0]) + pmid_pkg::SUM_W'(s4_q[1]) +
                pmid_pkg::SUM_W'(s4_q[2]);

  always_ff @(posedge clk_i) begin
    if (en5) s5_q <= s5_d;
  end

  logic [pmid_pkg::ROOT_W-1:0] root;

  pmid_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (s5_v_q),
    .ready_o    (sq_ready),
    .radicand_i (s5_q),
    .valid_o    (out_valid_o),
    .stall_i    (out_stall_i),
    .root_o     (root)
  );

  assign distance_o = pmid_pkg::DIST_W'(root);

  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_v_q)
    else $error("input stalled with empty first stage");

  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> s1_v_q)
    else $error("accepted request lost at first stage");

  a_wrap_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_v_q && !en3) |=> (s2_v_q && $stable(s2_q[0]) && $stable(s2_q[1])
                          && $stable(s2_q[2])))
    else $error("held wrap stage changed");

  a_sum_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s5_v_q && !sq_ready) |=> (s5_v_q && $stable(s5_q)))
    else $error("held sum stage changed");

endmodule
`default_nettype wire

@@ rtl/pmid_sqrt.sv @@
`default_nettype none
module pmid_sqrt (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          valid_i,
  output logic                               ready_o,
  input  wire logic [pmid_pkg::SUM_W-1:0]    radicand_i,
  output logic                               valid_o,
  input  wire logic                          stall_i,
  output logic      [pmid_pkg::ROOT_W-1:0]   root_o
);

  localparam int unsigned NS = pmid_pkg::SQ_STAGES;

  logic [NS-1:0]   v_q;
  logic [NS-1:0]   v_in;
  logic [NS:0]     en;
  pmid_pkg::sq_t   src   [NS];
  pmid_pkg::sq_t   stg_d [NS];
  pmid_pkg::sq_t   stg_q [NS];

  assign en[NS] = !stall_i;
  assign src[0] = '{rad: radicand_i, rem: '0, root: '0};
  assign v_in   = {v_q[NS-2:0], valid_i};

  for (genvar j = 0; j < NS; j++) begin : g_stg
    assign en[j] = !v_q[j] || en[j+1];

    if (j > 0) begin : g_src
      assign src[j] = stg_q[j-1];
    end

    always_comb begin
      stg_d[j] = src[j];
      for (int k = 0; k < pmid_pkg::SQ_PER_STG; k++) begin
        if (j * pmid_pkg::SQ_PER_STG + k < pmid_pkg::SQ_STEPS) begin
          stg_d[j] = pmid_pkg::sq_step(stg_d[j]);
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j] <= 1'b0;
      end else if (en[j]) begin
        v_q[j] <= v_in[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[j]) begin
        stg_q[j] <= stg_d[j];
      end
    end
  end

  assign ready_o = en[0];
  assign valid_o = v_q[NS-1];
  assign root_o  = stg_q[NS-1].root;

endmodule
`default_nettype wire

@@ sim/periodic_min_image_distance_core_tb.sv @@
`timescale 1ns / 1ps
module periodic_min_image_distance_core_tb;
  import pmid_pkg::*;

  localparam int LATENCY         = 18;
  localparam int ITEMS_PER_PHASE = 205;
  localparam int N_PHASES        = 7;
  localparam int PRESSURE_PHASE  = 4;
  localparam int NO_IDLE_PHASE   = 2;
  localparam int HOLD_LEN        = 120;

  localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic [CELL_W-1:0]         CELL_MAX  = '1;
  localparam logic [TOL_W-1:0]          TOL_MAX   = '1;

  typedef struct packed {
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic signed [COORD_W-1:0] pz;
    logic signed [COORD_W-1:0] qx;
    logic signed [COORD_W-1:0] qy;
    logic signed [COORD_W-1:0] qz;
  } point_pair_t;

  class distance_scoreboard;
    logic [DIST_W-1:0] expected_dist[$];
    logic [CELL_W-1:0] cell_len[N_AXES];
    logic [TOL_W-1:0]  wrap_tol;
    int                errors;

    function void load_defaults();
      foreach (cell_len[i]) cell_len[i] = CELL_LEN_RST;
      wrap_tol = WRAP_TOL_RST;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_CELL_LEN_X: cell_len[0] = data[CELL_W-1:0];
        CFG_CELL_LEN_Y: cell_len[1] = data[CELL_W-1:0];
        CFG_CELL_LEN_Z: cell_len[2] = data[CELL_W-1:0];
        CFG_WRAP_TOL:   wrap_tol    = data[TOL_W-1:0];
        default: ;
      endcase
    endfunction

    // squared minimum-image separation on one axis, wrapped at most once
    function logic [SUM_W-1:0] axis_square(logic signed [COORD_W-1:0] a,
                                           logic signed [COORD_W-1:0] b,
                                           logic [CELL_W-1:0] len);
      logic signed [COORD_W:0]   diff;
      logic [COORD_W-1:0]        mag;
      logic signed [COORD_W+1:0] wrapped;
      logic [COORD_W:0]          wmag;
      logic [SUM_W-1:0]          sq;
      diff    = a - b;
      mag     = COORD_W'((diff < 0) ? -diff : diff);
      wrapped = $signed({2'b00, mag});
      if ((26'(mag) * 2) > (26'(len) + 26'(wrap_tol) * 2))
        wrapped = $signed({2'b00, mag}) - $signed({3'b000, len});
      wmag = (COORD_W+1)'((wrapped < 0) ? -wrapped : wrapped);
      sq   = wmag * wmag;
      return sq;
    endfunction

    function logic [DIST_W-1:0] floor_root(logic [SUM_W-1:0] v);
      logic [DIST_W-1:0]   r;
      logic [DIST_W-1:0]   cand;
      logic [2*DIST_W-1:0] cand_sq;
      r = '0;
      for (int b = DIST_W - 1; b >= 0; b--) begin
        cand    = r | (DIST_W'(1) << b);
        cand_sq = cand * cand;
        if (cand_sq <= (2*DIST_W)'(v)) r = cand;
      end
      return r;
    endfunction

    function logic [DIST_W-1:0] min_image_distance(point_pair_t pr);
      logic [SUM_W-1:0] sum;
      sum = axis_square(pr.px, pr.qx, cell_len[0])
          + axis_square(pr.py, pr.qy, cell_len[1])
          + axis_square(pr.pz, pr.qz, cell_len[2]);
      return floor_root(sum);
    endfunction

    function void note_request(point_pair_t pr);
      expected_dist.push_back(min_image_distance(pr));
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 100) $display("%0t mismatch: %s", $time, msg);
    endtask

    task check_distance(logic [DIST_W-1:0] got);
      logic [DIST_W-1:0] want;
      if (expected_dist.size() == 0) begin
        report($sformatf("distance %0d with no request outstanding", got));
        return;
      end
      want = expected_dist.pop_front();
      if (got !== want) report($sformatf("distance %0d, expected %0d", got, want));
    endtask
  endclass

  logic                         clk;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_stall;
  logic signed [COORD_W-1:0]    px, py, pz, qx, qy, qz;
  logic                         out_valid;
  logic                         out_stall;
  logic [DIST_W-1:0]            distance;
  logic                         cfg_valid;
  logic                         cfg_ready;
  logic [CFG_IDX_W-1:0]         cfg_index;
  logic [CFG_DATA_W-1:0]        cfg_data;

  int send_idle_pct = 36;
  int stall_pct     = 36;
  int hold_cycles   = 0;

  distance_scoreboard sb;

  periodic_min_image_distance_core DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .p_x_i       (px),
    .p_y_i       (py),
    .p_z_i       (pz),
    .q_x_i       (qx),
    .q_y_i       (qy),
    .q_z_i       (qz),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .distance_o  (distance),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // receiver: random stalls, plus a long hold when requested
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        hold_cycles--;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_distance(distance);
  end

  function automatic point_pair_t mk_pair(logic signed [COORD_W-1:0] ax, ay, az, bx, by, bz);
    point_pair_t pr;
    pr = '{px: ax, py: ay, pz: az, qx: bx, qy: by, qz: bz};
    return pr;
  endfunction

  task automatic push_pair(input point_pair_t pr);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    px <= pr.px;
    py <= pr.py;
    pz <= pr.pz;
    qx <= pr.qx;
    qy <= pr.qy;
    qz <= pr.qz;
    do @(posedge clk); while (in_stall);
    sb.note_request(pr);
    @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    while (sb.expected_dist.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // one axis: mostly points within a cell or near the wrap threshold, some anywhere
  task automatic pick_axis(input logic [CELL_W-1:0] len,
                           output logic signed [COORD_W-1:0] a,
                           output logic signed [COORD_W-1:0] b);
    longint      span, d, lo, hi, av;
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 25) begin
      a = COORD_W'($urandom);
      b = COORD_W'($urandom);
    end else begin
      if (sel < 45)
        span = (longint'(len) + 2 * longint'(sb.wrap_tol)) / 2 - 1 + $urandom_range(3);
      else
        span = $urandom_range(len);
      if (span < 0) span = 0;
      d  = $urandom_range(1) ? -span : span;
      lo = (d >= 0) ? longint'(COORD_MIN) + d : longint'(COORD_MIN);
      hi = (d >= 0) ? longint'(COORD_MAX) : longint'(COORD_MAX) + d;
      av = lo + longint'($urandom_range(int'(hi - lo)));
      a  = COORD_W'(av);
      b  = COORD_W'(av - d);
    end
  endtask

  task automatic random_pair(output point_pair_t pr);
    pick_axis(sb.cell_len[0], pr.px, pr.qx);
    pick_axis(sb.cell_len[1], pr.py, pr.qy);
    pick_axis(sb.cell_len[2], pr.pz, pr.qz);
  endtask

  task automatic run_directed();
    point_pair_t dir[$];
    dir.push_back(mk_pair(0, 0, 0, 0, 0, 0));
    dir.push_back(mk_pair(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN));
    dir.push_back(mk_pair(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX));
    dir.push_back(mk_pair(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
    dir.push_back(mk_pair(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN));
    // on and just past the wrap threshold with reset cell and margin
    dir.push_back(mk_pair(16388, 0, 0, 0, 0, 0));
    dir.push_back(mk_pair(16389, 0, 0, 0, 0, 0));
    dir.push_back(mk_pair(0, 0, 0, 0, 16389, 0));
    dir.push_back(mk_pair(0, 0, 0, 0, 0, 16388));
    dir.push_back(mk_pair(16389, -16389, 16389, 0, 0, 0));
    dir.push_back(mk_pair(24'sh2AAAAA, 24'sh555555, 24'shAAAAAA, 24'sh555555, 24'sh2AAAAA,
                          24'sh555555));
    dir.push_back(mk_pair(24'sh555555, 24'shAAAAAA, 24'sh555555, 24'shAAAAAA, 24'sh555555,
                          24'sh2AAAAA));
    // a whole cell apart, and farther than one cell
    dir.push_back(mk_pair(32768, 0, 0, 0, 0, 0));
    dir.push_back(mk_pair(0, 40000, 0, 0, 0, 0));
    dir.push_back(mk_pair(4096, 4096, 4096, 0, 0, 0));
    dir.push_back(mk_pair(-1, -1, -1, 0, 0, 0));
    dir.push_back(mk_pair(COORD_MAX, 0, 0, 0, 0, 0));
    foreach (dir[i]) push_pair(dir[i]);
    in_valid <= 1'b0;
  endtask

  task automatic configure_phase(input int ph);
    case (ph)
      1: begin
        cfg_write(CFG_CELL_LEN_X, CELL_MAX);
        cfg_write(CFG_CELL_LEN_Y, CELL_MAX);
        cfg_write(CFG_CELL_LEN_Z, CELL_MAX);
        cfg_write(CFG_WRAP_TOL, CFG_DATA_W'(TOL_MAX));
      end
      2: begin
        cfg_write(CFG_CELL_LEN_X, 1);
        cfg_write(CFG_CELL_LEN_Y, 1);
        cfg_write(CFG_CELL_LEN_Z, 1);
        cfg_write(CFG_WRAP_TOL, 0);
      end
      4: begin
        cfg_write(CFG_CELL_LEN_X, CFG_DATA_W'($urandom_range(1, 1 << 16)));
        cfg_write(CFG_CELL_LEN_Y, CFG_DATA_W'($urandom_range(1, 1 << 16)));
        cfg_write(CFG_CELL_LEN_Z, CFG_DATA_W'($urandom_range(1, 1 << 16)));
        cfg_write(CFG_WRAP_TOL, CFG_DATA_W'($urandom));
        // indices past the register list must be ignored
        for (int unsigned i = CFG_WRAP_TOL + 1; i < (1 << CFG_IDX_W); i++)
          cfg_write(CFG_IDX_W'(i), CFG_DATA_W'($urandom));
      end
      5: begin
        // zero cell length: no wrap offset, test against margin only
        cfg_write(CFG_CELL_LEN_X, 0);
        cfg_write(CFG_CELL_LEN_Y, CFG_DATA_W'($urandom_range(1, CELL_MAX)));
        cfg_write(CFG_CELL_LEN_Z, CFG_DATA_W'($urandom_range(1, 1 << 14)));
        cfg_write(CFG_WRAP_TOL, {{(CFG_DATA_W-TOL_W){1'b1}}, TOL_W'($urandom)});
      end
      3, 6: begin
        cfg_write(CFG_CELL_LEN_X, CFG_DATA_W'($urandom_range(1, CELL_MAX)));
        cfg_write(CFG_CELL_LEN_Y, CFG_DATA_W'($urandom_range(1, CELL_MAX)));
        cfg_write(CFG_CELL_LEN_Z, CFG_DATA_W'($urandom_range(1, CELL_MAX)));
        cfg_write(CFG_WRAP_TOL, CFG_DATA_W'($urandom));
      end
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  initial begin
    point_pair_t pr;
    sb = new();
    sb.load_defaults();
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    px        = '0;
    py        = '0;
    pz        = '0;
    qx        = '0;
    qy        = '0;
    qz        = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    run_directed();
    wait_drained();

    for (int ph = 0; ph < N_PHASES; ph++) begin
      configure_phase(ph);
      send_idle_pct = (ph == NO_IDLE_PHASE) ? 0 : (ph == PRESSURE_PHASE) ? 10 : 36;
      stall_pct     = (ph == NO_IDLE_PHASE) ? 0 : 36;
      if (ph == PRESSURE_PHASE) hold_cycles = HOLD_LEN;
      repeat (ITEMS_PER_PHASE) begin
        random_pair(pr);
        push_pair(pr);
      end
      in_valid <= 1'b0;
      wait_drained();
    end

    repeat (LATENCY + 4) @(posedge clk);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout");
    $display("*** FAILED ***");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/pmid_pkg.sv
rtl/pmid_sqrt.sv
rtl/periodic_min_image_distance_core.sv
sim/periodic_min_image_distance_core_tb.sv
